@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the mixer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define EMDM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mixer check failed");

// Check that a condition never holds on a rising edge out of reset.
`define EMDM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mixer forbidden condition");

`endif

@@ hdl/emdm_pkg.sv @@
// ----------------------------------------------------------------------------
// emdm_pkg
// Types, register codes and constants of the earpiece mic delay mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package emdm_pkg;

  localparam int unsigned SAMPLE_BITS   = 24;
  localparam int unsigned GAIN_BITS     = 16;
  localparam int unsigned DLY_BITS      = 10;
  localparam int unsigned MODE_BITS     = 3;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned COEF_BITS     = 4;
  localparam int unsigned FRAC_SHIFT    = 12;
  localparam int unsigned MIX_SHIFT     = 14;
  localparam int unsigned ROUND_BIAS    = 1 << (MIX_SHIFT - 1);
  localparam int unsigned GC_BITS       = GAIN_BITS + COEF_BITS;
  localparam int unsigned PF_BITS       = SAMPLE_BITS + COEF_BITS;
  localparam int unsigned PR_BITS       = SAMPLE_BITS + GC_BITS;
  localparam int unsigned ACC_BITS      = PR_BITS + 1;

  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << FRAC_SHIFT);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [MODE_BITS-1:0] {
    FR_FRONT,
    FR_REAR,
    FR_IN_PHASE,
    FR_INVERTED,
    FR_INV_DELAY
  } fr_mode_e;

  typedef enum logic [MODE_BITS-1:0] {
    LR_STEREO,
    LR_MONO,
    LR_MUTE,
    LR_LEFT,
    LR_RIGHT
  } lr_mode_e;

  typedef enum logic {
    SRC_ANALOG,
    SRC_MIC
  } src_sel_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FR_MODE,
    REG_REAR_GAIN,
    REG_FRONT_DELAY,
    REG_REAR_DELAY,
    REG_SOURCE_SEL,
    REG_LR_MODE
  } cfg_reg_e;

  typedef struct packed {
    fr_mode_e              fr_mode;
    logic [GAIN_BITS-1:0]  rear_gain;
    logic [DLY_BITS-1:0]   front_delay;
    logic [DLY_BITS-1:0]   rear_delay;
    src_sel_e              source_select;
    lr_mode_e              lr_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fr_mode:       FR_FRONT,
    rear_gain:     GAIN_UNITY,
    front_delay:   '0,
    rear_delay:    '0,
    source_select: SRC_MIC,
    lr_mode:       LR_STEREO
  };

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_front;
    logic signed [SAMPLE_BITS-1:0] left_rear;
    logic signed [SAMPLE_BITS-1:0] right_front;
    logic signed [SAMPLE_BITS-1:0] right_rear;
    logic signed [SAMPLE_BITS-1:0] analog_left;
    logic signed [SAMPLE_BITS-1:0] analog_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } out_item_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] cf;
    logic signed [COEF_BITS-1:0] cr;
  } coef_t;

  // front and rear weights in quarters
  function automatic coef_t mix_coef(fr_mode_e mode);
    coef_t c;
    unique case (mode)
      FR_FRONT: begin
        c.cf = 4'sd4;
        c.cr = 4'sd0;
      end
      FR_REAR: begin
        c.cf = 4'sd0;
        c.cr = 4'sd4;
      end
      FR_IN_PHASE: begin
        c.cf = 4'sd2;
        c.cr = 4'sd2;
      end
      FR_INVERTED, FR_INV_DELAY: begin
        c.cf = 4'sd3;
        c.cr = -4'sd3;
      end
      default: begin
        c.cf = 4'sd3;
        c.cr = -4'sd3;
      end
    endcase
    return c;
  endfunction

endpackage

@@ hdl/emdm_fifo.sv @@
// ----------------------------------------------------------------------------
// emdm_fifo
// Short register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emdm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             wr_en, rd_en;

  always_comb begin
    full_o  = (cnt_q == NW'(DEPTH));
    empty_o = (cnt_q == '0);
    wr_en   = push_i && !full_o;
    rd_en   = pop_i && !empty_o;
    data_o  = mem_q[rd_q];
    wr_d    = wr_q;
    rd_d    = rd_q;
    if (wr_en) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (rd_en) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    cnt_d = cnt_q + NW'(wr_en) - NW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

@@ hdl/emdm_front.sv @@
// ----------------------------------------------------------------------------
// emdm_front
// Frame intake: front and rear delay memories, write position and history fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emdm_front #(
  parameter int unsigned DELAY_DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  emdm_pkg::cfg_t     cfg_i,
  input  logic               push_i,
  input  emdm_pkg::in_item_t data_i,
  output logic               full_o,
  output logic               busy_o,
  output logic               q_push_o,
  output emdm_pkg::in_item_t q_data_o,
  input  logic               q_full_i
);

  import emdm_pkg::*;

  localparam int unsigned AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int unsigned CW = ((AW > DLY_BITS) ? AW : DLY_BITS) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0] LAST_A  = AW'(DELAY_DEPTH - 1);

  logic [2*SAMPLE_BITS-1:0] ram_f [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] ram_r [DELAY_DEPTH];
  logic [2*SAMPLE_BITS-1:0] rdata_f_q, rdata_r_q;

  logic [AW-1:0] wp_q, wp_d, fill_q, fill_d;
  logic [AW-1:0] raddr_f, raddr_r;
  logic [CW-1:0] dly_f, dly_r;
  logic          accept;
  logic          s1_valid_q, s1_valid_d;
  in_item_t      s1_cur_q;
  logic          byp_f_q, byp_r_q, zero_f_q, zero_r_q;

  function automatic logic [CW-1:0] clamp_dly(logic [DLY_BITS-1:0] d);
    logic [CW-1:0] dx;
    dx = CW'(d);
    return (dx > LAST_C) ? LAST_C : dx;
  endfunction

  function automatic logic [AW-1:0] rd_addr(logic [AW-1:0] wp, logic [CW-1:0] d);
    logic [CW-1:0] wpx;
    wpx = CW'(wp);
    if (wpx >= d) begin
      return AW'(wpx - d);
    end
    return AW'(wpx + DEPTH_C - d);
  endfunction

  always_comb begin
    full_o   = s1_valid_q && q_full_i;
    q_push_o = s1_valid_q && !q_full_i;
    busy_o   = s1_valid_q;
    accept   = push_i && !full_o;

    if (cfg_i.fr_mode == FR_INV_DELAY) begin
      dly_f = clamp_dly(cfg_i.front_delay);
      dly_r = clamp_dly(cfg_i.rear_delay);
    end else begin
      dly_f = '0;
      dly_r = '0;
    end
    raddr_f = rd_addr(wp_q, dly_f);
    raddr_r = rd_addr(wp_q, dly_r);

    wp_d       = wp_q;
    fill_d     = fill_q;
    s1_valid_d = s1_valid_q && !q_push_o;
    if (accept) begin
      wp_d       = (wp_q == LAST_A) ? '0 : wp_q + AW'(1);
      fill_d     = (fill_q == LAST_A) ? fill_q : fill_q + AW'(1);
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      fill_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wp_q       <= wp_d;
      fill_q     <= fill_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ram_f[wp_q] <= {data_i.right_front, data_i.left_front};
      ram_r[wp_q] <= {data_i.right_rear, data_i.left_rear};
      rdata_f_q   <= ram_f[raddr_f];
      rdata_r_q   <= ram_r[raddr_r];
      s1_cur_q    <= data_i;
      byp_f_q     <= (dly_f == '0);
      byp_r_q     <= (dly_r == '0);
      zero_f_q    <= (dly_f > CW'(fill_q));
      zero_r_q    <= (dly_r > CW'(fill_q));
    end
  end

  always_comb begin
    q_data_o              = s1_cur_q;
    if (!byp_f_q) begin
      q_data_o.left_front  = zero_f_q ? '0 : sample_t'(rdata_f_q[SAMPLE_BITS-1:0]);
      q_data_o.right_front = zero_f_q ? '0 :
                             sample_t'(rdata_f_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    end
    if (!byp_r_q) begin
      q_data_o.left_rear   = zero_r_q ? '0 : sample_t'(rdata_r_q[SAMPLE_BITS-1:0]);
      q_data_o.right_rear  = zero_r_q ? '0 :
                             sample_t'(rdata_r_q[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    end
  end

endmodule

@@ hdl/emdm_back.sv @@
// ----------------------------------------------------------------------------
// emdm_back
// Front/rear mix with rear gain, source switch, left-right matrix, result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module emdm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emdm_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  emdm_pkg::in_item_t  q_data_i,
  output logic                q_pop_o,
  output logic                busy_o,
  input  logic                pop_i,
  output logic                empty_o,
  output emdm_pkg::out_item_t data_o
);

  import emdm_pkg::*;

  coef_t                        coef;
  logic signed [COEF_BITS-1:0]  cf_q;
  logic signed [GC_BITS-1:0]    gc_q, gc_d;

  logic                         a_valid_q, a_valid_d;
  logic signed [PF_BITS-1:0]    pf_l_q, pf_r_q, pf_l_d, pf_r_d;
  logic signed [PR_BITS-1:0]    pr_l_q, pr_r_q, pr_l_d, pr_r_d;
  sample_t                      an_l_q, an_r_q;

  sample_t                      ml, mr, sl, sr;
  logic signed [SAMPLE_BITS:0]  avg_sum;
  out_item_t                    res;
  logic                         o_push, o_full;

  function automatic sample_t mix_sat(logic signed [PF_BITS-1:0] pf,
                                      logic signed [PR_BITS-1:0] pr);
    logic signed [ACC_BITS-1:0]           acc;
    logic signed [ACC_BITS-MIX_SHIFT-1:0] rnd;
    acc = (ACC_BITS'(pf) <<< FRAC_SHIFT) + ACC_BITS'(pr)
          + $signed(ACC_BITS'(ROUND_BIAS));
    rnd = acc[ACC_BITS-1:MIX_SHIFT];
    if (rnd > SMP_MAX) begin
      return SMP_MAX;
    end
    if (rnd < SMP_MIN) begin
      return SMP_MIN;
    end
    return rnd[SAMPLE_BITS-1:0];
  endfunction

  always_comb begin
    coef = mix_coef(cfg_i.fr_mode);
    gc_d = GC_BITS'(coef.cr) * GC_BITS'($signed({1'b0, cfg_i.rear_gain}));
  end

  always_ff @(posedge clk_i) begin
    cf_q <= coef.cf;
    gc_q <= gc_d;
  end

  always_comb begin
    q_pop_o   = !q_empty_i && (!a_valid_q || !o_full);
    o_push    = a_valid_q && !o_full;
    a_valid_d = q_pop_o || (a_valid_q && o_full);
    busy_o    = a_valid_q;
    pf_l_d    = q_data_i.left_front * cf_q;
    pf_r_d    = q_data_i.right_front * cf_q;
    pr_l_d    = q_data_i.left_rear * gc_q;
    pr_r_d    = q_data_i.right_rear * gc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pf_l_q <= pf_l_d;
      pf_r_q <= pf_r_d;
      pr_l_q <= pr_l_d;
      pr_r_q <= pr_r_d;
      an_l_q <= q_data_i.analog_left;
      an_r_q <= q_data_i.analog_right;
    end
  end

  always_comb begin
    ml      = mix_sat(pf_l_q, pr_l_q);
    mr      = mix_sat(pf_r_q, pr_r_q);
    sl      = (cfg_i.source_select == SRC_MIC) ? ml : an_l_q;
    sr      = (cfg_i.source_select == SRC_MIC) ? mr : an_r_q;
    avg_sum = (SAMPLE_BITS+1)'(sl) + (SAMPLE_BITS+1)'(sr) + (SAMPLE_BITS+1)'(1);
    unique case (cfg_i.lr_mode)
      LR_STEREO: begin
        res.out_left  = sl;
        res.out_right = sr;
      end
      LR_MONO: begin
        res.out_left  = avg_sum[SAMPLE_BITS:1];
        res.out_right = avg_sum[SAMPLE_BITS:1];
      end
      LR_MUTE: begin
        res.out_left  = '0;
        res.out_right = '0;
      end
      LR_LEFT: begin
        res.out_left  = sl;
        res.out_right = sl;
      end
      LR_RIGHT: begin
        res.out_left  = sr;
        res.out_right = sr;
      end
      default: begin
        res.out_left  = sl;
        res.out_right = sr;
      end
    endcase
  end

  emdm_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (o_push),
    .data_i  (res),
    .full_o  (o_full),
    .pop_i   (pop_i),
    .data_o  (data_o),
    .empty_o (empty_o)
  );

endmodule

@@ hdl/earpiece_mic_delay_mixer.sv @@
// ----------------------------------------------------------------------------
// earpiece_mic_delay_mixer
// Delays, mixes and routes four earpiece mics and two analog inputs to stereo.
//
// Frames come in on a queue-style port: a transfer happens on a rising edge
// with push high and full low. Results leave the same way: the oldest result
// sits on out_data_o while empty is low and is taken on a rising edge with
// pop high. Registers are written on the cfg port (index, data) with
// cfg_valid and cfg_ready high; cfg_ready is always high, and writes belong
// only in idle periods. Undefined mode codes and unknown indexes are dropped.
// A frame passes the intake stage, middle queue, product register and result
// queue. Throughput: one frame per cycle while pop keeps up, set by one write
// and one read of each delay memory per frame. A short queue sits between
// intake and mixer and another before the result port; when pop stays low they
// fill and full rises, nothing is lost. Reset restores register defaults, sets
// the write position and history count to zero; history not yet written reads
// as silence, so no clearing pass runs and frames are taken right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module earpiece_mic_delay_mixer #(
  parameter int unsigned DELAY_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  input  emdm_pkg::in_item_t                  in_data_i,
  output logic                                full,
  input  logic                                pop,
  output logic                                empty,
  output emdm_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [emdm_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [emdm_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);

  import emdm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  in_item_t q_wdata, q_rdata;
  logic     q_push, q_full, q_pop, q_empty;
  logic     front_busy, back_busy;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_i)
        REG_FR_MODE: begin
          if (cfg_data_i[MODE_BITS-1:0] <= FR_INV_DELAY) begin
            cfg_d.fr_mode = fr_mode_e'(cfg_data_i[MODE_BITS-1:0]);
          end
        end
        REG_REAR_GAIN:   cfg_d.rear_gain     = cfg_data_i[GAIN_BITS-1:0];
        REG_FRONT_DELAY: cfg_d.front_delay   = cfg_data_i[DLY_BITS-1:0];
        REG_REAR_DELAY:  cfg_d.rear_delay    = cfg_data_i[DLY_BITS-1:0];
        REG_SOURCE_SEL:  cfg_d.source_select = src_sel_e'(cfg_data_i[0]);
        REG_LR_MODE: begin
          if (cfg_data_i[MODE_BITS-1:0] <= LR_RIGHT) begin
            cfg_d.lr_mode = lr_mode_e'(cfg_data_i[MODE_BITS-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  emdm_front #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .data_i   (in_data_i),
    .full_o   (full),
    .busy_o   (front_busy),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  emdm_fifo #(
    .WIDTH ($bits(in_item_t)),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  emdm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .busy_o    (back_busy),
    .pop_i     (pop),
    .empty_o   (empty),
    .data_o    (out_data_o)
  );

  `EMDM_ASSERT(a_push_loads_front, clk_i, rst_ni, (push && !full) |=> front_busy)
  `EMDM_ASSERT(a_full_held_by_queue, clk_i, rst_ni, full |-> (front_busy && q_full))
  `EMDM_ASSERT(a_pop_loads_back, clk_i, rst_ni, q_pop |=> back_busy)
  `EMDM_ASSERT_NEVER(a_no_pop_when_empty, clk_i, rst_ni, q_pop && q_empty)

endmodule

@@ tb/tb_earpiece_mic_delay_mixer.sv @@
// ----------------------------------------------------------------------------
// tb_earpiece_mic_delay_mixer
// Self-checking bench for the earpiece mic delay mixer. Frames go in through
// the push/full port with random gaps. Results are popped with random stalls.
// A tracker class keeps its own copy of the registers and the four mic delay
// lines. It predicts each stereo result in fixed point and checks it field by
// field. The run starts with a short directed part: sample extremes, every
// front-rear mode, every left-right matrix, the analog source, rounding,
// saturation, and dropped register writes. Random phases follow. Each phase
// writes registers while the mixer is idle and then streams frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_earpiece_mic_delay_mixer;
  import emdm_pkg::*;

  localparam int unsigned LINE_DEPTH  = 1024;
  localparam int unsigned FRAME_COUNT = 1600;
  localparam int unsigned LATENCY     = 3;
  localparam time         TIMEOUT_NS  = 20_000_000;

  class stereo_mix_tracker;
    cfg_t             regs;
    sample_t          line_mem [4][LINE_DEPTH];
    logic [DLY_BITS-1:0] wr_pos;
    out_item_t        stereo_due_q [$];
    int unsigned      n_frames;
    int unsigned      n_checked;
    int unsigned      n_errors;

    function new();
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      regs      = CFG_RESET;
      wr_pos    = '0;
      n_frames  = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_FR_MODE:     if (data[2:0] <= FR_INV_DELAY) regs.fr_mode = fr_mode_e'(data[2:0]);
        REG_REAR_GAIN:   regs.rear_gain = data[GAIN_BITS-1:0];
        REG_FRONT_DELAY: regs.front_delay = data[DLY_BITS-1:0];
        REG_REAR_DELAY:  regs.rear_delay = data[DLY_BITS-1:0];
        REG_SOURCE_SEL:  regs.source_select = src_sel_e'(data[0]);
        REG_LR_MODE:     if (data[2:0] <= LR_RIGHT) regs.lr_mode = lr_mode_e'(data[2:0]);
        default: ;
      endcase
    endfunction

    function sample_t clip(longint v);
      if (v > longint'(SMP_MAX)) return SMP_MAX;
      if (v < longint'(SMP_MIN)) return SMP_MIN;
      return sample_t'(v);
    endfunction

    function sample_t tap(int line, sample_t s, logic [DLY_BITS-1:0] d);
      logic [DLY_BITS-1:0] rd;
      line_mem[line][wr_pos] = s;
      rd = wr_pos - d;
      return line_mem[line][rd];
    endfunction

    function sample_t mix_pair(sample_t fr, sample_t rr);
      longint cf, cr, acc;
      case (regs.fr_mode)
        FR_FRONT: begin
          cf = 4;
          cr = 0;
        end
        FR_REAR: begin
          cf = 0;
          cr = 4;
        end
        FR_IN_PHASE: begin
          cf = 2;
          cr = 2;
        end
        default: begin
          cf = 3;
          cr = -3;
        end
      endcase
      acc = cf * (longint'(fr) <<< FRAC_SHIFT) + cr * (longint'(rr) * longint'(regs.rear_gain));
      return clip((acc + longint'(ROUND_BIAS)) >>> MIX_SHIFT);
    endfunction

    function void take_frame(in_item_t f);
      logic [DLY_BITS-1:0] fd, rd;
      sample_t lf, lr, rf, rr, sl, sr;
      out_item_t want;
      fd = '0;
      rd = '0;
      if (regs.fr_mode == FR_INV_DELAY) begin
        fd = regs.front_delay;
        rd = regs.rear_delay;
      end
      lf = tap(0, f.left_front, fd);
      lr = tap(1, f.left_rear, rd);
      rf = tap(2, f.right_front, fd);
      rr = tap(3, f.right_rear, rd);
      wr_pos = wr_pos + 1'b1;
      if (regs.source_select == SRC_MIC) begin
        sl = mix_pair(lf, lr);
        sr = mix_pair(rf, rr);
      end else begin
        sl = f.analog_left;
        sr = f.analog_right;
      end
      case (regs.lr_mode)
        LR_MONO: begin
          want.out_left  = clip((longint'(sl) + longint'(sr) + 1) >>> 1);
          want.out_right = want.out_left;
        end
        LR_MUTE: begin
          want.out_left  = '0;
          want.out_right = '0;
        end
        LR_LEFT: begin
          want.out_left  = sl;
          want.out_right = sl;
        end
        LR_RIGHT: begin
          want.out_left  = sr;
          want.out_right = sr;
        end
        default: begin
          want.out_left  = sl;
          want.out_right = sr;
        end
      endcase
      stereo_due_q.push_back(want);
      n_frames++;
    endfunction

    function void check_stereo(out_item_t got);
      out_item_t want;
      if (stereo_due_q.size() == 0) begin
        $display("%0t: result with no frame pending: expected none, actual %0d %0d",
                 $time, got.out_left, got.out_right);
        n_errors++;
        return;
      end
      want = stereo_due_q.pop_front();
      n_checked++;
      if (got.out_left !== want.out_left) begin
        $display("%0t: out_left mismatch: expected %0d, actual %0d",
                 $time, want.out_left, got.out_left);
        n_errors++;
      end
      if (got.out_right !== want.out_right) begin
        $display("%0t: out_right mismatch: expected %0d, actual %0d",
                 $time, want.out_right, got.out_right);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return stereo_due_q.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push;
  in_item_t                  in_data_i;
  logic                      full;
  logic                      pop;
  logic                      empty;
  out_item_t                 out_data_o;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;

  stereo_mix_tracker sb;
  int unsigned       send_gap_max;
  int unsigned       n_cfg_writes;
  int unsigned       n_phases;

  earpiece_mic_delay_mixer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_data_i  (in_data_i),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data_o),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return sample_t'(int'($urandom_range(0, 63)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t frame_of(sample_t f, sample_t r, sample_t a);
    in_item_t fr;
    fr.left_front   = f;
    fr.left_rear    = r;
    fr.right_front  = r;
    fr.right_rear   = f;
    fr.analog_left  = a;
    fr.analog_right = ~a;
    return fr;
  endfunction

  task automatic send_frame(input in_item_t frame);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    in_data_i <= frame;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.take_frame(frame);
    @(negedge clk_i);
  endtask

  // hold off frames until every pending result has been popped
  task automatic settle();
    push <= 1'b0;
    do @(negedge clk_i); while (sb.pending() > 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.apply_reg(idx, data);
    n_cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic close_cfg();
    cfg_valid <= 1'b0;
  endtask

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : drain_results
    int unsigned gap, stall_max, n_pops;
    stall_max = 6;
    n_pops    = 0;
    pop       = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (n_pops % 64 == 0) stall_max = $urandom_range(0, 1) ? 6 : 0;
      gap = $urandom_range(0, stall_max);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_stereo(out_data_o);
      n_pops++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_BITS-1:0] wdata;
    int unsigned              sel, n_burst;
    in_item_t                 fr;

    push         = 1'b0;
    in_data_i    = '0;
    cfg_valid    = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    send_gap_max = 0;
    n_cfg_writes = 0;
    n_phases     = 0;
    sb           = new();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // register defaults straight out of reset
    send_frame(frame_of(SMP_MAX, SMP_MAX, SMP_MAX));
    send_frame(frame_of(SMP_MIN, SMP_MIN, SMP_MIN));

    // each front-rear mode at full rear gain, paired with one matrix setting
    send_gap_max = 3;
    for (int m = FR_FRONT; m <= FR_INV_DELAY; m++) begin
      settle();
      write_reg(REG_FR_MODE, CFG_DATA_BITS'(m));
      write_reg(REG_LR_MODE, CFG_DATA_BITS'(m));
      write_reg(REG_REAR_GAIN, '1);
      if (m == FR_INV_DELAY) begin
        write_reg(REG_FRONT_DELAY, CFG_DATA_BITS'(1));
        write_reg(REG_REAR_DELAY, '1);
      end
      close_cfg();
      n_phases++;
      send_frame(frame_of(SMP_MAX, SMP_MIN, '0));
      send_frame(frame_of(SMP_MIN, SMP_MAX, SMP_MAX));
      send_frame(frame_of(sample_t'(1), '0, sample_t'(-1)));
    end

    // analog source through the mono average
    settle();
    write_reg(REG_SOURCE_SEL, CFG_DATA_BITS'(SRC_ANALOG));
    write_reg(REG_LR_MODE, CFG_DATA_BITS'(LR_MONO));
    close_cfg();
    n_phases++;
    send_frame(frame_of(SMP_MAX, SMP_MIN, SMP_MAX));
    send_frame(frame_of('0, '0, sample_t'(2)));

    // undefined mode codes and unknown indexes must be dropped
    settle();
    write_reg(REG_FR_MODE, CFG_DATA_BITS'(FR_INV_DELAY + 1));
    write_reg(REG_LR_MODE, '1);
    write_reg(CFG_IDX_BITS'(REG_LR_MODE + 1), '0);
    write_reg('1, '1);
    write_reg(REG_SOURCE_SEL, CFG_DATA_BITS'(SRC_MIC));
    close_cfg();
    n_phases++;
    send_frame(frame_of(SMP_MIN, SMP_MAX, SMP_MIN));
    send_frame(frame_of(sample_t'(-1), sample_t'(1), '0));

    while (sb.n_frames < FRAME_COUNT) begin
      settle();
      for (int i = 0; i < (1 << CFG_IDX_BITS); i++) begin
        if ($urandom_range(0, 1)) begin
          wdata = CFG_DATA_BITS'($urandom);
          case (i)
            REG_FR_MODE, REG_LR_MODE: begin
              sel = $urandom_range(0, 9);
              if ($urandom_range(0, 1)) wdata[CFG_DATA_BITS-1:3] = '0;
              wdata[2:0] = (sel < 8) ? 3'(sel % 5) : 3'($urandom_range(FR_INV_DELAY + 1, 7));
            end
            REG_REAR_GAIN: begin
              case ($urandom_range(0, 3))
                0: wdata = '0;
                1: wdata = '1;
                2: wdata = GAIN_UNITY;
                default: ;
              endcase
            end
            REG_FRONT_DELAY, REG_REAR_DELAY: begin
              case ($urandom_range(0, 3))
                0: wdata[DLY_BITS-1:0] = '0;
                1: wdata[DLY_BITS-1:0] = '1;
                2: wdata[DLY_BITS-1:0] = DLY_BITS'($urandom_range(1, 8));
                default: ;
              endcase
            end
            default: ;
          endcase
          write_reg(CFG_IDX_BITS'(i), wdata);
        end
      end
      close_cfg();
      n_phases++;
      send_gap_max = $urandom_range(0, 1) ? 6 : 0;
      n_burst      = $urandom_range(10, 90);
      repeat (n_burst) begin
        fr.left_front   = pick_sample();
        fr.left_rear    = pick_sample();
        fr.right_front  = pick_sample();
        fr.right_rear   = pick_sample();
        fr.analog_left  = pick_sample();
        fr.analog_right = pick_sample();
        send_frame(fr);
      end
    end

    push <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);

    $display("Run covered %0d frames in %0d phases with %0d register writes.",
             sb.n_frames, n_phases, n_cfg_writes);
    $display("%0d stereo results checked, %0d mismatches.", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/emdm_pkg.sv
hdl/emdm_fifo.sv
hdl/emdm_front.sv
hdl/emdm_back.sv
hdl/earpiece_mic_delay_mixer.sv
tb/tb_earpiece_mic_delay_mixer.sv
